@@ design/printf_output_length_bound_top_assert.svh @@
// assertion macros for the format string length bound block
// used by the port checker; needs i_clk and i_rst_n in the scope of use
`ifndef PRINTF_OUTPUT_LENGTH_BOUND_TOP_ASSERT_SVH
`define PRINTF_OUTPUT_LENGTH_BOUND_TOP_ASSERT_SVH

// condition implies consequence in the same cycle
`define POBL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define POBL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/pobl_pkg.sv @@
// types and constants of the format string length bound block
// no dependencies; imported by every module of the block except pobl_checker
`default_nettype none

package pobl_pkg;

    // position inside a conversion
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_PCT    = 3'd1,
        PH_DOTS   = 3'd2,
        PH_DIGITS = 3'd3,
        PH_H      = 3'd4,
        PH_HH     = 3'd5,
        PH_L      = 3'd6,
        PH_LL     = 3'd7
    } t_phase;

    // one input item
    typedef struct packed {
        logic [7:0] char_byte;
        logic       last_byte;
        logic       no_byte;
    } t_item;

    // one result item
    typedef struct packed {
        logic [15:0] total_length;
        logic        length_saturated;
    } t_result;

    // character codes
    localparam logic [7:0] CH_PCT = 8'h25;
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_0   = 8'h30;
    localparam logic [7:0] CH_9   = 8'h39;
    localparam logic [7:0] CH_C   = 8'h63;
    localparam logic [7:0] CH_D   = 8'h64;
    localparam logic [7:0] CH_H   = 8'h68;
    localparam logic [7:0] CH_L   = 8'h6C;
    localparam logic [7:0] CH_S   = 8'h73;
    localparam logic [7:0] CH_U   = 8'h75;
    localparam logic [7:0] CH_X   = 8'h78;
    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_TAB = 8'h09;

    // worst-case printed lengths
    localparam int unsigned LEN_W = 5;
    localparam logic [LEN_W-1:0] LEN_NONE = 5'd0;
    localparam logic [LEN_W-1:0] LEN_LIT  = 5'd1;
    localparam logic [LEN_W-1:0] LEN_CTRL = 5'd2;
    localparam logic [LEN_W-1:0] LEN_C    = 5'd1;
    localparam logic [LEN_W-1:0] LEN_D    = 5'd10;
    localparam logic [LEN_W-1:0] LEN_X    = 5'd8;
    localparam logic [LEN_W-1:0] LEN_HD   = 5'd5;
    localparam logic [LEN_W-1:0] LEN_HX   = 5'd4;
    localparam logic [LEN_W-1:0] LEN_HHD  = 5'd3;
    localparam logic [LEN_W-1:0] LEN_HHX  = 5'd2;
    localparam logic [LEN_W-1:0] LEN_LD   = 5'd19;
    localparam logic [LEN_W-1:0] LEN_LU   = 5'd20;
    localparam logic [LEN_W-1:0] LEN_LX   = 5'd16;

    // result field range
    localparam int unsigned OUT_W = 16;
    localparam logic [OUT_W-1:0] OUT_MAX = 16'hFFFF;

    // byte counter, saturating
    localparam logic [1:0] SEEN_ONE  = 2'd1;
    localparam logic [1:0] SEEN_TWO  = 2'd2;
    localparam logic [1:0] SEEN_FULL = 2'd3;

endpackage

`default_nettype wire

@@ design/pobl_in_reg.sv @@
// input register stage of the format string length bound block
// depends on pobl_pkg for the item type
`default_nettype none

module pobl_in_reg
    import pobl_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_item i_item,
    output logic       o_valid,
    output t_item      o_item,
    input  wire logic  i_take
);

    logic  r_valid;
    t_item r_item;

    // refill whenever the held item moves on or the stage is empty
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

@@ design/pobl_core.sv @@
// conversion parser and saturating length accumulator
// depends on pobl_pkg for phases, character codes and lengths
`default_nettype none

module pobl_core
    import pobl_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_take,
    input  wire t_item i_item,
    output t_result    o_result
);

    localparam int unsigned SUM_W  = COUNT_WIDTH + 2;
    localparam int unsigned WIDE_W = (COUNT_WIDTH > OUT_W) ? COUNT_WIDTH : OUT_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    // string state
    t_phase                 r_phase,   n_phase;
    logic [COUNT_WIDTH-1:0] r_pending, n_pending;
    logic [COUNT_WIDTH-1:0] r_total,   n_total;
    logic [1:0]             r_seen,    n_seen;
    logic                   r_ovf,     n_ovf;
    logic                   r_pct_s,   n_pct_s;

    // decode of the byte against the current phase
    logic [7:0]       c;
    logic             is_digit;
    logic             spec_ok;
    logic             spec_grow;
    logic             spec_fin;
    t_phase           grow_phase;
    logic [LEN_W-1:0] fin_len;

    // byte handling
    logic             has_byte;
    logic             fail;
    logic             as_lit;
    logic             pct_start;
    logic             do_grow;
    logic             do_fin;
    logic             end_add;
    logic             use_pend;
    logic [LEN_W-1:0] k_len;
    logic [SUM_W-1:0] sum;
    logic             sum_sat;
    logic             grow_ovf;

    // result
    logic [WIDE_W-1:0] wide_total;
    logic              clip;

    assign c        = i_item.char_byte;
    assign has_byte = !i_item.no_byte;

    // what the byte does inside a conversion
    always_comb begin
        is_digit   = (c >= CH_0) && (c <= CH_9);
        spec_ok    = 1'b1;
        spec_grow  = 1'b0;
        spec_fin   = 1'b0;
        grow_phase = PH_IDLE;
        fin_len    = LEN_NONE;
        unique case (r_phase)
            PH_IDLE: begin
                spec_ok = 1'b0;
            end
            PH_PCT, PH_DOTS, PH_DIGITS: begin
                priority if (c == CH_C && r_phase == PH_PCT) begin
                    spec_fin = 1'b1;
                    fin_len  = LEN_C;
                end else if (c == CH_DOT && r_phase != PH_DIGITS) begin
                    spec_grow  = 1'b1;
                    grow_phase = PH_DOTS;
                end else if (is_digit) begin
                    spec_grow  = 1'b1;
                    grow_phase = PH_DIGITS;
                end else if (c == CH_D || c == CH_U) begin
                    spec_fin = 1'b1;
                    fin_len  = LEN_D;
                end else if (c == CH_X) begin
                    spec_fin = 1'b1;
                    fin_len  = LEN_X;
                end else if (c == CH_H) begin
                    spec_grow  = 1'b1;
                    grow_phase = PH_H;
                end else if (c == CH_L) begin
                    spec_grow  = 1'b1;
                    grow_phase = PH_L;
                end else begin
                    spec_ok = 1'b0;
                end
            end
            PH_H: begin
                priority if (c == CH_D || c == CH_U) begin
                    spec_fin = 1'b1;
                    fin_len  = LEN_HD;
                end else if (c == CH_X) begin
                    spec_fin = 1'b1;
                    fin_len  = LEN_HX;
                end else if (c == CH_H) begin
                    spec_grow  = 1'b1;
                    grow_phase = PH_HH;
                end else begin
                    spec_ok = 1'b0;
                end
            end
            PH_HH: begin
                priority if (c == CH_D || c == CH_U) begin
                    spec_fin = 1'b1;
                    fin_len  = LEN_HHD;
                end else if (c == CH_X) begin
                    spec_fin = 1'b1;
                    fin_len  = LEN_HHX;
                end else begin
                    spec_ok = 1'b0;
                end
            end
            PH_L, PH_LL: begin
                priority if (c == CH_D) begin
                    spec_fin = 1'b1;
                    fin_len  = LEN_LD;
                end else if (c == CH_U) begin
                    spec_fin = 1'b1;
                    fin_len  = LEN_LU;
                end else if (c == CH_X) begin
                    spec_fin = 1'b1;
                    fin_len  = LEN_LX;
                end else if (c == CH_L && r_phase == PH_L) begin
                    spec_grow  = 1'b1;
                    grow_phase = PH_LL;
                end else begin
                    spec_ok = 1'b0;
                end
            end
        endcase
    end

    // next state: a failed conversion flushes its bytes, then the byte is a literal;
    // a conversion left open at the end of the string is flushed in the same add
    always_comb begin
        fail      = has_byte && (r_phase != PH_IDLE) && !spec_ok;
        as_lit    = has_byte && ((r_phase == PH_IDLE) || fail);
        pct_start = as_lit && (c == CH_PCT);
        do_grow   = has_byte && spec_ok && spec_grow;
        do_fin    = has_byte && spec_ok && spec_fin;

        priority if (pct_start) begin
            n_phase   = PH_PCT;
            n_pending = COUNT_WIDTH'(1);
        end else if (as_lit) begin
            n_phase   = PH_IDLE;
            n_pending = '0;
        end else if (do_grow) begin
            n_phase   = grow_phase;
            n_pending = (r_pending == CNT_MAX) ? CNT_MAX : r_pending + COUNT_WIDTH'(1);
        end else if (do_fin) begin
            n_phase   = PH_IDLE;
            n_pending = '0;
        end else begin
            n_phase   = r_phase;
            n_pending = r_pending;
        end

        // closing flush of an open conversion on the final item
        end_add  = i_item.last_byte && (n_phase != PH_IDLE);
        use_pend = fail || (end_add && !pct_start);

        priority if (as_lit && !pct_start) begin
            k_len = ((c == CH_NL) || (c == CH_TAB)) ? LEN_CTRL : LEN_LIT;
        end else if (do_fin) begin
            k_len = fin_len;
        end else if (end_add && (pct_start || do_grow)) begin
            k_len = LEN_LIT;
        end else begin
            k_len = LEN_NONE;
        end

        // one saturating add covers flush, literal and conversion
        sum     = SUM_W'(r_total) + (use_pend ? SUM_W'(r_pending) : SUM_W'(0))
                  + SUM_W'(k_len);
        sum_sat = sum > SUM_W'(CNT_MAX);
        n_total = sum_sat ? CNT_MAX : sum[COUNT_WIDTH-1:0];

        grow_ovf = do_grow && !i_item.last_byte && (r_pending == CNT_MAX);
        n_ovf    = r_ovf || sum_sat || grow_ovf;

        n_pct_s  = r_pct_s || (has_byte && (r_seen == SEEN_ONE) && (r_phase == PH_PCT)
                               && (c == CH_S));
        n_seen   = (has_byte && (r_seen != SEEN_FULL)) ? r_seen + 2'd1 : r_seen;
    end

    // result of the final item
    always_comb begin
        wide_total = WIDE_W'(n_total);
        clip       = wide_total > WIDE_W'(OUT_MAX);
        if ((n_seen == SEEN_TWO) && n_pct_s) begin
            o_result.total_length     = '0;
            o_result.length_saturated = 1'b0;
        end else begin
            o_result.total_length     = clip ? OUT_MAX : wide_total[OUT_W-1:0];
            o_result.length_saturated = n_ovf || clip;
        end
    end

    // state registers, cleared after each final item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_pending <= '0;
            r_total   <= '0;
            r_seen    <= '0;
            r_ovf     <= 1'b0;
            r_pct_s   <= 1'b0;
        end else if (i_take) begin
            if (i_item.last_byte) begin
                r_phase   <= PH_IDLE;
                r_pending <= '0;
                r_total   <= '0;
                r_seen    <= '0;
                r_ovf     <= 1'b0;
                r_pct_s   <= 1'b0;
            end else begin
                r_phase   <= n_phase;
                r_pending <= n_pending;
                r_total   <= n_total;
                r_seen    <= n_seen;
                r_ovf     <= n_ovf;
                r_pct_s   <= n_pct_s;
            end
        end
    end

endmodule

`default_nettype wire

@@ design/pobl_out_reg.sv @@
// result register of the format string length bound block
// depends on pobl_pkg for the result type
`default_nettype none

module pobl_out_reg
    import pobl_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_result,
    output logic         o_free,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_result
);

    logic    r_valid;
    t_result r_result;

    // a new result may enter when the slot is empty or is being taken
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

@@ design/printf_output_length_bound_top.sv @@
// Worst-case printed length of a format string, fed one byte per item. Every
// item, including the last, is taken at one item per clock while the input
// does not stall. An item is held in an input register, then the parser and
// saturating adder update the string state and, for the item marked last,
// write the result register, from which the result is presented to the
// output side. The input stalls only while a last item waits for a result
// register that is still held by the output side. The running sum is
// COUNT_WIDTH bits wide and saturates; the reported length saturates at
// 65535.
// depends on pobl_pkg, pobl_in_reg, pobl_core and pobl_out_reg
`default_nettype none

module printf_output_length_bound_top
    import pobl_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] char_byte
    input  wire logic        i_s_tlast,   // last_byte
    input  wire logic        i_s_tuser,   // [0] no_byte
    // result stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata,   // [15:0] total_length
    output logic             o_m_tuser    // [0] length_saturated
);

    t_item   in_item;
    t_item   held_item;
    logic    held_valid;
    logic    take;
    logic    out_free;
    t_result core_result;
    t_result out_result;

    assign in_item.char_byte = i_s_tdata;
    assign in_item.last_byte = i_s_tlast;
    assign in_item.no_byte   = i_s_tuser;

    pobl_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_item  (in_item),
        .o_valid (held_valid),
        .o_item  (held_item),
        .i_take  (take)
    );

    // a final item waits until the result slot is free
    assign take = held_valid && (!held_item.last_byte || out_free);

    pobl_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_item   (held_item),
        .o_result (core_result)
    );

    pobl_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (take && held_item.last_byte),
        .i_result (core_result),
        .o_free   (out_free),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (out_result)
    );

    assign o_m_tdata = out_result.total_length;
    assign o_m_tuser = out_result.length_saturated;

endmodule

`default_nettype wire

@@ design/pobl_checker.sv @@
// port-level checker for the format string length bound block
// depends on printf_output_length_bound_top_assert.svh; bound to the top level
`default_nettype none

`include "printf_output_length_bound_top_assert.svh"

module pobl_checker #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_s_tready,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [15:0] o_m_tdata,
    input wire logic        o_m_tuser
);

    localparam logic [15:0] SAT_LEN =
        (COUNT_WIDTH >= 16) ? 16'hFFFF : 16'((64'd1 << COUNT_WIDTH) - 64'd1);

    // a stalled result holds
    `POBL_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser), "stalled result changed")

    // the input side stalls only behind a blocked result
    `POBL_ASSERT_NOW(a_stall_cause, !o_s_tready, o_m_tvalid && !i_m_tready, "input stalled without a blocked result")

    // a saturated result sits at the top of its range
    `POBL_ASSERT_NOW(a_sat_value, o_m_tvalid && o_m_tuser, o_m_tdata == SAT_LEN, "saturated result not at maximum")

    // a zero length never carries the saturation flag
    `POBL_ASSERT_NOW(a_zero_flag, o_m_tvalid && (o_m_tdata == 16'd0), !o_m_tuser, "zero length flagged as saturated")

endmodule

bind printf_output_length_bound_top pobl_checker #(
    .COUNT_WIDTH (COUNT_WIDTH)
) u_pobl_checker (.*);

`default_nettype wire

@@ bench/tb_printf_output_length_bound_top.sv @@
// testbench for printf_output_length_bound_top: format strings are fed one byte per item
// and each reported worst-case length is checked against a cycle-free predictor or
// a typed directed row; depends on pobl_pkg and printf_output_length_bound_top
`default_nettype none

module tb_printf_output_length_bound_top
    import pobl_pkg::*;
;

    // counter width under test: the default width of the block
    localparam int unsigned    CW        = 16;
    localparam logic [CW-1:0]  CNT_MAX   = {CW{1'b1}};
    localparam int             ITEM_GOAL = 320;
    localparam int             RX_HOLD   = 80;
    localparam int             IDLE_LIMIT = 2000;
    localparam int             DOT_RUN   = 40;

    // one row of the directed table
    typedef struct packed {
        logic [7:0]  b;
        logic        lst;
        logic        nb;
        logic        chk;
        logic [15:0] len;
        logic        sat;
    } t_row;

    localparam int N_DIR = 26;
    localparam t_row DIR_ROWS [N_DIR] = '{
        // empty string
        '{8'h00,  1'b1, 1'b1, 1'b1, 16'd0,  1'b0},
        // exactly %s
        '{CH_PCT, 1'b0, 1'b0, 1'b0, 16'd0,  1'b0},
        '{CH_S,   1'b1, 1'b0, 1'b1, 16'd0,  1'b0},
        // %d
        '{CH_PCT, 1'b0, 1'b0, 1'b0, 16'd0,  1'b0},
        '{CH_D,   1'b1, 1'b0, 1'b1, 16'd10, 1'b0},
        // %llu
        '{CH_PCT, 1'b0, 1'b0, 1'b0, 16'd0,  1'b0},
        '{CH_L,   1'b0, 1'b0, 1'b0, 16'd0,  1'b0},
        '{CH_L,   1'b0, 1'b0, 1'b0, 16'd0,  1'b0},
        '{CH_U,   1'b1, 1'b0, 1'b1, 16'd20, 1'b0},
        // %hhx
        '{CH_PCT, 1'b0, 1'b0, 1'b0, 16'd0,  1'b0},
        '{CH_H,   1'b0, 1'b0, 1'b0, 16'd0,  1'b0},
        '{CH_H,   1'b0, 1'b0, 1'b0, 16'd0,  1'b0},
        '{CH_X,   1'b1, 1'b0, 1'b1, 16'd2,  1'b0},
        // bare %c
        '{CH_PCT, 1'b0, 1'b0, 1'b0, 16'd0,  1'b0},
        '{CH_C,   1'b1, 1'b0, 1'b1, 16'd1,  1'b0},
        // newline and tab
        '{CH_NL,  1'b0, 1'b0, 1'b0, 16'd0,  1'b0},
        '{CH_TAB, 1'b1, 1'b0, 1'b1, 16'd4,  1'b0},
        // failed conversion, percent restarting, then dots and digits failing on q
        '{CH_PCT, 1'b0, 1'b0, 1'b0, 16'd0,  1'b0},
        '{CH_PCT, 1'b0, 1'b0, 1'b0, 16'd0,  1'b0},
        '{CH_DOT, 1'b0, 1'b0, 1'b0, 16'd0,  1'b0},
        '{8'h35,  1'b0, 1'b0, 1'b0, 16'd0,  1'b0},
        '{8'h71,  1'b1, 1'b0, 1'b0, 16'd0,  1'b0},
        // byte extremes
        '{8'hFF,  1'b0, 1'b0, 1'b0, 16'd0,  1'b0},
        '{8'h00,  1'b1, 1'b0, 1'b1, 16'd2,  1'b0},
        // conversion left open at the end
        '{CH_PCT, 1'b0, 1'b0, 1'b0, 16'd0,  1'b0},
        '{8'h35,  1'b1, 1'b0, 1'b0, 16'd0,  1'b0}
    };

    // clock, reset and block ports
    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata  = 8'h00;  // [7:0] char_byte
    logic        i_s_tlast  = 1'b0;   // last_byte
    logic        i_s_tuser  = 1'b0;   // [0] no_byte
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;           // [15:0] total_length
    logic        o_m_tuser;           // [0] length_saturated

    // expectation typed into the directed table, travelling with its item
    logic        row_typed  = 1'b0;
    t_result     row_expect = '0;

    // bench control
    bit          calm    = 1'b0;
    bit          hold_rx = 1'b0;
    int          rand_items = 0;
    int          fail_cnt   = 0;
    int          idle_cycles = 0;
    t_result     exp_lengths [$];
    logic [8:0]  fmt_text [$];        // [8] no_byte, [7:0] char_byte

    // predictor state
    t_phase         fmt_phase;
    logic [CW-1:0]  spec_bytes;
    logic [CW-1:0]  len_sum;
    logic [1:0]     byte_cnt;
    logic           sum_ovf;
    logic           pct_s_seen;

    always #5 i_clk = ~i_clk;

    printf_output_length_bound_top #(
        .COUNT_WIDTH(CW)
    ) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tlast (i_s_tlast),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser)
    );

    // ---------------------------------------------------------------- predictor

    function automatic void clear_state();
        fmt_phase  = PH_IDLE;
        spec_bytes = '0;
        len_sum    = '0;
        byte_cnt   = '0;
        sum_ovf    = 1'b0;
        pct_s_seen = 1'b0;
    endfunction

    // saturating add, any saturation raises the flag
    function automatic logic [CW-1:0] add_sat(input logic [CW-1:0] a, input logic [CW-1:0] b);
        logic [CW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[CW]) begin
            sum_ovf = 1'b1;
            return CNT_MAX;
        end
        return s[CW-1:0];
    endfunction

    function automatic void close_spec(input logic [CW-1:0] n);
        len_sum    = add_sat(len_sum, n);
        spec_bytes = '0;
        fmt_phase  = PH_IDLE;
    endfunction

    function automatic void extend_spec(input t_phase nxt);
        spec_bytes = add_sat(spec_bytes, CW'(1));
        fmt_phase  = nxt;
    endfunction

    // byte outside any conversion
    function automatic void plain_byte(input logic [7:0] c);
        if (c == CH_PCT) begin
            fmt_phase  = PH_PCT;
            spec_bytes = CW'(1);
        end else if (c == CH_NL || c == CH_TAB) begin
            len_sum = add_sat(len_sum, CW'(LEN_CTRL));
        end else begin
            len_sum = add_sat(len_sum, CW'(LEN_LIT));
        end
    endfunction

    // byte inside a conversion, 1 if the conversion took it
    function automatic bit spec_byte(input logic [7:0] c);
        bit digit;
        digit = (c >= CH_0) && (c <= CH_9);
        case (fmt_phase)
            PH_PCT, PH_DOTS, PH_DIGITS: begin
                if (c == CH_C && fmt_phase == PH_PCT) begin
                    close_spec(CW'(LEN_C));
                    return 1'b1;
                end
                if (c == CH_DOT && fmt_phase != PH_DIGITS) begin
                    extend_spec(PH_DOTS);
                    return 1'b1;
                end
                if (digit) begin
                    extend_spec(PH_DIGITS);
                    return 1'b1;
                end
                if (c == CH_D || c == CH_U) begin
                    close_spec(CW'(LEN_D));
                    return 1'b1;
                end
                if (c == CH_X) begin
                    close_spec(CW'(LEN_X));
                    return 1'b1;
                end
                if (c == CH_H) begin
                    extend_spec(PH_H);
                    return 1'b1;
                end
                if (c == CH_L) begin
                    extend_spec(PH_L);
                    return 1'b1;
                end
            end
            PH_H: begin
                if (c == CH_D || c == CH_U) begin
                    close_spec(CW'(LEN_HD));
                    return 1'b1;
                end
                if (c == CH_X) begin
                    close_spec(CW'(LEN_HX));
                    return 1'b1;
                end
                if (c == CH_H) begin
                    extend_spec(PH_HH);
                    return 1'b1;
                end
            end
            PH_HH: begin
                if (c == CH_D || c == CH_U) begin
                    close_spec(CW'(LEN_HHD));
                    return 1'b1;
                end
                if (c == CH_X) begin
                    close_spec(CW'(LEN_HHX));
                    return 1'b1;
                end
            end
            PH_L, PH_LL: begin
                if (c == CH_D) begin
                    close_spec(CW'(LEN_LD));
                    return 1'b1;
                end
                if (c == CH_U) begin
                    close_spec(CW'(LEN_LU));
                    return 1'b1;
                end
                if (c == CH_X) begin
                    close_spec(CW'(LEN_LX));
                    return 1'b1;
                end
                if (c == CH_L && fmt_phase == PH_L) begin
                    extend_spec(PH_LL);
                    return 1'b1;
                end
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    // one accepted item, 1 with the result when the item ends a string
    function automatic bit predict_length(input logic [7:0] c, input logic lst, input logic nb,
                                          output t_result res);
        logic [31:0] wide;
        res = '0;
        if (!nb) begin
            if (byte_cnt == SEEN_ONE && fmt_phase == PH_PCT && c == CH_S)
                pct_s_seen = 1'b1;
            if (fmt_phase == PH_IDLE) begin
                plain_byte(c);
            end else if (!spec_byte(c)) begin
                // failed conversion: its bytes are literals, this byte starts afresh
                close_spec(spec_bytes);
                plain_byte(c);
            end
            if (byte_cnt != SEEN_FULL)
                byte_cnt = byte_cnt + 2'd1;
        end
        if (!lst)
            return 1'b0;
        if (fmt_phase != PH_IDLE)
            close_spec(spec_bytes);
        // exact %s gives zero, anything else the clamped sum
        if (!(byte_cnt == SEEN_TWO && pct_s_seen)) begin
            wide = 32'(len_sum);
            res.length_saturated = sum_ovf;
            if (wide > 32'(OUT_MAX)) begin
                res.total_length     = OUT_MAX;
                res.length_saturated = 1'b1;
            end else begin
                res.total_length = wide[15:0];
            end
        end
        clear_state();
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------- monitors

    task automatic log_fail(input string msg);
        fail_cnt++;
        if (fail_cnt <= 10)
            $display("%s", msg);
    endtask

    // input side: predict on every accepted item
    always @(posedge i_clk) begin : in_mon
        t_result guess;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            if (predict_length(i_s_tdata, i_s_tlast, i_s_tuser, guess))
                exp_lengths.push_back(row_typed ? row_expect : guess);
        end
    end

    // result side: compare with the oldest expectation
    always @(posedge i_clk) begin : out_mon
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (exp_lengths.size() == 0) begin
                log_fail($sformatf("length %0d sat %0d arrived with nothing expected",
                                   o_m_tdata, o_m_tuser));
            end else begin
                want = exp_lengths.pop_front();
                if (o_m_tdata !== want.total_length || o_m_tuser !== want.length_saturated)
                    log_fail($sformatf("length mismatch: expected %0d sat %0d, got %0d sat %0d",
                                       want.total_length, want.length_saturated,
                                       o_m_tdata, o_m_tuser));
            end
        end
    end

    // watchdog on cycles without any item moving
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("** printf_output_length_bound_top: FAILED **");
            $finish;
        end
    end

    // ---------------------------------------------------------------- result side

    // random back-pressure, with one long hold when asked
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_rx) begin
                i_m_tready <= 1'b0;
                repeat (RX_HOLD) @(negedge i_clk);
                hold_rx = 1'b0;
            end else begin
                i_m_tready <= calm || ($urandom_range(99) >= 15);
            end
        end
    end

    // ---------------------------------------------------------------- input side

    task automatic put_item(input logic [7:0] b, input logic lst, input logic nb,
                            input logic typed, input t_result want);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 15) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= lst;
        i_s_tuser  <= nb;
        row_typed  <= typed;
        row_expect <= want;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // stop offering and wait for every outstanding length
    task automatic wait_drained();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (exp_lengths.size() != 0);
    endtask

    task automatic send_text();
        for (int i = 0; i < fmt_text.size(); i++) begin
            put_item(fmt_text[i][7:0], i == fmt_text.size() - 1, fmt_text[i][8], 1'b0, '0);
            if (!fmt_text[i][8] || i == fmt_text.size() - 1)
                rand_items++;
        end
    endtask

    // random string, mostly well-formed conversions with some noise
    task automatic send_string();
        int n_tok;
        int r;
        int k;
        int n;
        fmt_text.delete();
        calm = (rand_items >= 150) && (rand_items < 250);
        r = $urandom_range(99);
        if (r < 8) begin
            fmt_text.push_back({1'b0, CH_PCT});
            fmt_text.push_back({1'b0, CH_S});
        end else if (r >= 12) begin
            n_tok = ($urandom_range(7) == 0) ? $urandom_range(30, 15) : $urandom_range(6, 1);
            repeat (n_tok) begin
                r = $urandom_range(99);
                if (r < 25) begin
                    fmt_text.push_back({1'b0, 8'($urandom_range(255))});
                end else if (r < 35) begin
                    fmt_text.push_back({1'b0, $urandom_range(1) ? CH_NL : CH_TAB});
                end else if (r < 75) begin
                    // percent, dots, digits, length modifier, type
                    fmt_text.push_back({1'b0, CH_PCT});
                    n = ($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0;
                    repeat (n) fmt_text.push_back({1'b0, CH_DOT});
                    n = ($urandom_range(2) == 0) ? $urandom_range(3, 1) : 0;
                    repeat (n) fmt_text.push_back({1'b0, CH_0 + 8'($urandom_range(9))});
                    k = $urandom_range(4);
                    if (k == 1 || k == 2) fmt_text.push_back({1'b0, CH_H});
                    if (k == 2)           fmt_text.push_back({1'b0, CH_H});
                    if (k == 3 || k == 4) fmt_text.push_back({1'b0, CH_L});
                    if (k == 4)           fmt_text.push_back({1'b0, CH_L});
                    k = $urandom_range(2);
                    fmt_text.push_back({1'b0, (k == 0) ? CH_D : (k == 1) ? CH_U : CH_X});
                end else if (r < 80) begin
                    fmt_text.push_back({1'b0, CH_PCT});
                    fmt_text.push_back({1'b0, CH_C});
                end else if (r < 86) begin
                    fmt_text.push_back({1'b1, 8'($urandom_range(255))});
                end else if (r < 96) begin
                    // partial conversion ended by an arbitrary byte
                    fmt_text.push_back({1'b0, CH_PCT});
                    repeat ($urandom_range(2)) begin
                        case ($urandom_range(3))
                            0: fmt_text.push_back({1'b0, CH_DOT});
                            1: fmt_text.push_back({1'b0, CH_0 + 8'($urandom_range(9))});
                            2: fmt_text.push_back({1'b0, CH_H});
                            default: fmt_text.push_back({1'b0, CH_L});
                        endcase
                    end
                    fmt_text.push_back({1'b0, 8'($urandom_range(255))});
                end else begin
                    fmt_text.push_back({1'b0, CH_PCT});
                    fmt_text.push_back({1'b0, CH_S});
                end
            end
        end
        // empty string, or a string closed by an item without a byte
        if (fmt_text.size() == 0 || $urandom_range(5) == 0)
            fmt_text.push_back({1'b1, 8'($urandom_range(255))});
        send_text();
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        clear_state();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int i = 0; i < N_DIR; i++)
            put_item(DIR_ROWS[i].b, DIR_ROWS[i].lst, DIR_ROWS[i].nb, DIR_ROWS[i].chk,
                     {DIR_ROWS[i].len, DIR_ROWS[i].sat});

        // result side holds off while one-byte strings keep coming, so the input stalls
        hold_rx = 1'b1;
        repeat (12)
            put_item(8'($urandom_range(255)), 1'b1, 1'b0, 1'b0, '0);

        // sender pause until every length is back
        wait_drained();

        // random strings
        while (rand_items < ITEM_GOAL)
            send_string();
        calm = 1'b0;

        // long open conversion, flushed as literals at the end of the string
        fmt_text.delete();
        fmt_text.push_back({1'b0, CH_PCT});
        repeat (DOT_RUN) fmt_text.push_back({1'b0, CH_DOT});
        send_text();

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (fail_cnt == 0 && exp_lengths.size() == 0) begin
            $display("** printf_output_length_bound_top: PASSED **");
        end else begin
            $display("** printf_output_length_bound_top: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ printf_output_length_bound_top.f @@
+incdir+design
design/pobl_pkg.sv
design/pobl_in_reg.sv
design/pobl_core.sv
design/pobl_out_reg.sv
design/printf_output_length_bound_top.sv
design/pobl_checker.sv
bench/tb_printf_output_length_bound_top.sv
